// ===== rtl/nrcb_pkg.sv =====
`default_nettype none

package nrcb_pkg;

    // Port width of every pixel field, and the width the filter actually uses.
    localparam int PORT_W = 16;
    localparam int PIX_W  = 16;

    // Nine pixels plus rounding, and sixteen-weight blur plus rounding, fit here.
    localparam int SUM_W  = PIX_W + 4;

    localparam int MODE_W = 5;

    // Divide by nine as a multiply by a rounded-up reciprocal and a shift.
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [RECIP_W-1:0] DIV9_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);

    localparam logic [MODE_W-1:0] MODE_CLIP_MINMAX = 5'd1;
    localparam logic [MODE_W-1:0] MODE_CLIP_RANK4  = 5'd4;
    localparam logic [MODE_W-1:0] MODE_BLUR_A      = 5'd11;
    localparam logic [MODE_W-1:0] MODE_BLUR_B      = 5'd12;
    localparam logic [MODE_W-1:0] MODE_MEAN8       = 5'd19;
    localparam logic [MODE_W-1:0] MODE_MEAN9       = 5'd20;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [7:0][PIX_W-1:0] pix8_t;

    typedef enum logic [2:0] {
        CLS_PASS,
        CLS_CLIP,
        CLS_BLUR,
        CLS_MEAN8,
        CLS_MEAN9
    } op_cls_t;

    // Captured window, neighbors ordered UL, UM, UR, ML, MR, LL, LM, LR.
    typedef struct packed {
        pix_t  centre;
        pix8_t nbr;
        logic  border;
    } win_t;

    typedef struct packed {
        op_cls_t          cls;
        pix_t             centre;
        pix_t             lo;
        pix_t             hi;
        pix_t             avg;
        logic [SUM_W-1:0] sum9;
    } mid_t;

    function automatic op_cls_t mode_class(input logic [MODE_W-1:0] mode,
                                           input logic border);
        op_cls_t cls;
        begin
            cls = CLS_PASS;
            if (!border)
            begin
                if (mode inside {[MODE_CLIP_MINMAX:MODE_CLIP_RANK4]})
                    cls = CLS_CLIP;
                else if (mode inside {MODE_BLUR_A, MODE_BLUR_B})
                    cls = CLS_BLUR;
                else if (mode == MODE_MEAN8)
                    cls = CLS_MEAN8;
                else if (mode == MODE_MEAN9)
                    cls = CLS_MEAN9;
                else
                    cls = CLS_PASS;
            end
            return cls;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/neighborhood_rank_clip_blur_3x3.sv =====
`default_nettype none

// 3x3 rank-clip / blur filter. Pulse start with a window while busy is low and
// done pulses for one cycle with filtered_pixel; busy never rises, so a new
// window can be given every cycle and results come out in order at one per
// cycle. The window passes three register stages in order: the input
// register, a stage after the neighbor ranking and sums, and the result
// register after the clamp and divide-by-nine multiply. The receiver cannot
// stall, so done must be taken when it shows. Write filter_mode through
// cfg_valid/cfg_data only while no window is in flight.
module neighborhood_rank_clip_blur_3x3 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nrcb_pkg::MODE_W-1:0]   cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   centre_pixel,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   upper_left,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   upper_mid,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   upper_right,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   mid_left,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   mid_right,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   lower_left,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   lower_mid,
    input  wire logic [nrcb_pkg::PORT_W-1:0]   lower_right,
    input  wire logic                          on_border,
    output logic                               done,
    output logic [nrcb_pkg::PORT_W-1:0]        filtered_pixel
);
    import nrcb_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              accept;

    win_t win_reg;
    win_t win_next;
    logic win_vld_reg;

    mid_t mid_reg;
    mid_t mid_next;
    logic mid_vld_reg;

    pix_t res_reg;
    pix_t res_next;
    logic done_reg;

    pix_t       lo;
    pix_t       hi;
    pix_t       blur;
    pix_t       mean8;
    logic [SUM_W-1:0] sum9;
    logic [MODE_W-1:0] mode_off;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;

    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_comb
    begin
        win_next.centre = centre_pixel[PIX_W-1:0];
        win_next.nbr[0] = upper_left[PIX_W-1:0];
        win_next.nbr[1] = upper_mid[PIX_W-1:0];
        win_next.nbr[2] = upper_right[PIX_W-1:0];
        win_next.nbr[3] = mid_left[PIX_W-1:0];
        win_next.nbr[4] = mid_right[PIX_W-1:0];
        win_next.nbr[5] = lower_left[PIX_W-1:0];
        win_next.nbr[6] = lower_mid[PIX_W-1:0];
        win_next.nbr[7] = lower_right[PIX_W-1:0];
        win_next.border = on_border;
    end

    // Rank offset into the sorted neighbors: mode 1 picks min/max.
    assign mode_off = mode_reg - MODE_CLIP_MINMAX;

    nrcb_rank u_rank (
        .nbr      (win_reg.nbr),
        .rank_sel (mode_off[1:0]),
        .lo       (lo),
        .hi       (hi)
    );

    nrcb_sum u_sum (
        .centre (win_reg.centre),
        .nbr    (win_reg.nbr),
        .blur   (blur),
        .mean8  (mean8),
        .sum9   (sum9)
    );

    always_comb
    begin
        mid_next.cls    = mode_class(mode_reg, win_reg.border);
        mid_next.centre = win_reg.centre;
        mid_next.lo     = lo;
        mid_next.hi     = hi;
        mid_next.avg    = (mid_next.cls == CLS_BLUR) ? blur : mean8;
        mid_next.sum9   = sum9;
    end

    nrcb_final u_final (
        .mid (mid_reg),
        .pix (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            win_vld_reg <= 1'b0;
            mid_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            win_vld_reg <= accept;
            mid_vld_reg <= win_vld_reg;
            done_reg    <= mid_vld_reg;
        end
    end

    // Payload registers: load only behind a valid item.
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
        if (win_vld_reg)
            mid_reg <= mid_next;
        if (mid_vld_reg)
            res_reg <= res_next;
    end

    assign done           = done_reg;
    assign filtered_pixel = PORT_W'(res_reg);

endmodule

`default_nettype wire

// ===== rtl/nrcb_rank.sv =====
`default_nettype none

module nrcb_rank (
    input  wire nrcb_pkg::pix8_t nbr,
    input  wire logic [1:0]      rank_sel,
    output nrcb_pkg::pix_t       lo,
    output nrcb_pkg::pix_t       hi
);
    import nrcb_pkg::*;

    logic [7:0][2:0] rank;
    logic [2:0]      lo_rank;
    logic [2:0]      hi_rank;

    // Stable rank of each neighbor: count those smaller, ties broken by position.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rank[i] = 3'd0;
            for (int j = 0; j < 8; j++)
            begin
                if (j != i)
                begin
                    if ((nbr[j] < nbr[i]) || ((nbr[j] == nbr[i]) && (j < i)))
                        rank[i] = rank[i] + 3'd1;
                end
            end
        end
    end

    assign lo_rank = {1'b0, rank_sel};
    assign hi_rank = {1'b1, ~rank_sel};

    // Ranks are unique, so exactly one neighbor matches each selector.
    always_comb
    begin
        lo = '0;
        hi = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (rank[i] == lo_rank)
                lo = lo | nbr[i];
            if (rank[i] == hi_rank)
                hi = hi | nbr[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nrcb_sum.sv =====
`default_nettype none

module nrcb_sum (
    input  wire nrcb_pkg::pix_t        centre,
    input  wire nrcb_pkg::pix8_t       nbr,
    output nrcb_pkg::pix_t             blur,
    output nrcb_pkg::pix_t             mean8,
    output logic [nrcb_pkg::SUM_W-1:0] sum9
);
    import nrcb_pkg::*;

    logic [SUM_W-1:0] edge_sum;
    logic [SUM_W-1:0] corner_sum;
    logic [SUM_W-1:0] nbr_sum;
    logic [SUM_W-1:0] blur_sum;
    logic [SUM_W-1:0] mean8_sum;

    assign edge_sum   = SUM_W'(nbr[1]) + SUM_W'(nbr[3]) + SUM_W'(nbr[4]) + SUM_W'(nbr[6]);
    assign corner_sum = SUM_W'(nbr[0]) + SUM_W'(nbr[2]) + SUM_W'(nbr[5]) + SUM_W'(nbr[7]);
    assign nbr_sum    = edge_sum + corner_sum;

    assign blur_sum  = (SUM_W'(centre) << 2) + (edge_sum << 1) + corner_sum + SUM_W'(8);
    assign mean8_sum = nbr_sum + SUM_W'(4);

    assign blur  = blur_sum[PIX_W+3:4];
    assign mean8 = mean8_sum[PIX_W+2:3];
    assign sum9  = nbr_sum + SUM_W'(centre) + SUM_W'(4);

endmodule

`default_nettype wire

// ===== rtl/nrcb_final.sv =====
`default_nettype none

module nrcb_final (
    input  wire nrcb_pkg::mid_t mid,
    output nrcb_pkg::pix_t      pix
);
    import nrcb_pkg::*;

    logic [SUM_W+RECIP_W-1:0] prod;
    pix_t                     quot;
    pix_t                     clipped;

    assign prod = (SUM_W+RECIP_W)'(mid.sum9) * (SUM_W+RECIP_W)'(DIV9_RECIP);
    assign quot = prod[DIV_SHIFT+PIX_W-1:DIV_SHIFT];

    always_comb
    begin
        if (mid.centre < mid.lo)
            clipped = mid.lo;
        else if (mid.centre > mid.hi)
            clipped = mid.hi;
        else
            clipped = mid.centre;
    end

    always_comb
    begin
        case (mid.cls)
            CLS_CLIP:  pix = clipped;
            CLS_BLUR:  pix = mid.avg;
            CLS_MEAN8: pix = mid.avg;
            CLS_MEAN9: pix = quot;
            default:   pix = mid.centre;
        endcase
    end

endmodule

`default_nettype wire

// ===== test/tb_neighborhood_rank_clip_blur_3x3.sv =====
`timescale 1ns / 100ps

module tb_neighborhood_rank_clip_blur_3x3;
    import nrcb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_PASS       = 5'd0;
    localparam logic [MODE_W-1:0] MODE_CLIP_RANK2 = 5'd2;
    localparam logic [MODE_W-1:0] MODE_CLIP_RANK3 = 5'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = 5'd31;

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 950;
    localparam int CALM_ITEMS    = 150;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 25;

    typedef logic [0:7][PORT_W-1:0] nbr_set_t;

    typedef struct packed {
        logic [PORT_W-1:0] centre;
        nbr_set_t          nbr;
        logic              border;
    } window_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        window_t           win;
        logic              known;
        logic [PORT_W-1:0] known_pixel;
    } directed_row_t;

    // Active modes first, then the two pass-through extremes.
    localparam logic [MODE_W-1:0] MODE_WALK [10] = '{
        MODE_CLIP_MINMAX, MODE_CLIP_RANK2, MODE_CLIP_RANK3, MODE_CLIP_RANK4,
        MODE_BLUR_A, MODE_BLUR_B, MODE_MEAN8, MODE_MEAN9,
        MODE_PASS, MODE_UNUSED_TOP
    };

    localparam nbr_set_t SCRAMBLED = '{16'h0700, 16'h0200, 16'h0800, 16'h0100,
                                       16'h0600, 16'h0300, 16'h0400, 16'h0900};

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_PASS, '{16'h1234, '{16'h0001, 16'h8000, 16'hFFFF, 16'h0000,
                                   16'h4321, 16'h7FFF, 16'h00FF, 16'hFF00}, 1'b0},
          1'b1, 16'h1234},
        '{MODE_PASS, '{16'hFFFF, '{default: 16'h0000}, 1'b0}, 1'b1, 16'hFFFF},
        '{MODE_CLIP_MINMAX, '{16'h0000, '{default: 16'hFFFF}, 1'b0}, 1'b1, 16'hFFFF},
        '{MODE_CLIP_MINMAX, '{16'hFFFF, '{default: 16'h0000}, 1'b0}, 1'b1, 16'h0000},
        '{MODE_CLIP_MINMAX, '{16'h0500, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        // border position passes the centre in every mode
        '{MODE_CLIP_MINMAX, '{16'h0000, '{default: 16'hFFFF}, 1'b1}, 1'b1, 16'h0000},
        '{MODE_CLIP_RANK2, '{16'h0000, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_CLIP_RANK2, '{16'hFFFF, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_CLIP_RANK3, '{16'h0000, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_CLIP_RANK3, '{16'hFFFF, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_CLIP_RANK4, '{16'h0000, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_CLIP_RANK4, '{16'hFFFF, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_CLIP_RANK4, '{16'h0480, '{16'h0500, 16'h0400, 16'h0500, 16'h0400,
                                         16'h0500, 16'h0400, 16'h0500, 16'h0400}, 1'b0},
          1'b0, 16'h0000},
        '{MODE_BLUR_A, '{16'hFFFF, '{default: 16'hFFFF}, 1'b0}, 1'b1, 16'hFFFF},
        '{MODE_BLUR_A, '{16'h0000, '{default: 16'h0000}, 1'b0}, 1'b1, 16'h0000},
        '{MODE_BLUR_A, '{16'h8000, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_BLUR_B, '{16'h0007, '{16'h0001, 16'h0002, 16'h0003, 16'h0004,
                                     16'h0005, 16'h0006, 16'h0007, 16'h0008}, 1'b0},
          1'b0, 16'h0000},
        '{MODE_BLUR_B, '{16'hABCD, '{default: 16'hFFFF}, 1'b1}, 1'b1, 16'hABCD},
        '{MODE_MEAN8, '{16'h0000, '{default: 16'hFFFF}, 1'b0}, 1'b1, 16'hFFFF},
        '{MODE_MEAN8, '{16'h5555, SCRAMBLED, 1'b0}, 1'b0, 16'h0000},
        '{MODE_MEAN8, '{16'h0000, '{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                    16'h0000, 16'h0000, 16'h0000, 16'h0004}, 1'b0},
          1'b0, 16'h0000},
        '{MODE_MEAN9, '{16'hFFFF, '{default: 16'hFFFF}, 1'b0}, 1'b1, 16'hFFFF},
        '{MODE_MEAN9, '{16'h0000, '{default: 16'h0000}, 1'b0}, 1'b1, 16'h0000},
        '{MODE_MEAN9, '{16'h0005, '{default: 16'h0000}, 1'b0}, 1'b0, 16'h0000},
        '{MODE_UNUSED_TOP, '{16'h2468, SCRAMBLED, 1'b0}, 1'b1, 16'h2468}
    };

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_data     = '0;
    logic              start        = 1'b0;
    logic              busy;
    logic [PORT_W-1:0] centre_pixel = '0;
    logic [PORT_W-1:0] upper_left   = '0;
    logic [PORT_W-1:0] upper_mid    = '0;
    logic [PORT_W-1:0] upper_right  = '0;
    logic [PORT_W-1:0] mid_left     = '0;
    logic [PORT_W-1:0] mid_right    = '0;
    logic [PORT_W-1:0] lower_left   = '0;
    logic [PORT_W-1:0] lower_mid    = '0;
    logic [PORT_W-1:0] lower_right  = '0;
    logic              on_border    = 1'b0;
    logic              done;
    logic [PORT_W-1:0] filtered_pixel;

    logic [MODE_W-1:0] mode_shadow = MODE_PASS;
    logic [PORT_W-1:0] expected_pixels [$];
    int                mismatches  = 0;
    int                idle_cycles = 0;

    neighborhood_rank_clip_blur_3x3 i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .centre_pixel   (centre_pixel),
        .upper_left     (upper_left),
        .upper_mid      (upper_mid),
        .upper_right    (upper_right),
        .mid_left       (mid_left),
        .mid_right      (mid_right),
        .lower_left     (lower_left),
        .lower_mid      (lower_mid),
        .lower_right    (lower_right),
        .on_border      (on_border),
        .done           (done),
        .filtered_pixel (filtered_pixel)
    );

    always #10 clk = ~clk;

    function automatic logic [PORT_W-1:0] predict_filtered(input logic [MODE_W-1:0] mode,
                                                           input window_t w);
        logic [PIX_W-1:0] ranked [8];
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] res;
        int unsigned      acc;
        int               i;
        int               j;
        int               r;
        begin
            c = w.centre[PIX_W-1:0];
            for (i = 0; i < 8; i++)
                ranked[i] = w.nbr[i][PIX_W-1:0];
            res = c;
            if (!w.border)
            begin
                case (mode)
                    MODE_CLIP_MINMAX, MODE_CLIP_RANK2, MODE_CLIP_RANK3, MODE_CLIP_RANK4:
                    begin
                        for (i = 1; i < 8; i++)
                        begin
                            v = ranked[i];
                            j = i - 1;
                            while (j >= 0 && ranked[j] > v)
                            begin
                                ranked[j + 1] = ranked[j];
                                j--;
                            end
                            ranked[j + 1] = v;
                        end
                        r = int'(mode) - 1;
                        if (res < ranked[r])
                            res = ranked[r];
                        if (res > ranked[7 - r])
                            res = ranked[7 - r];
                    end
                    MODE_BLUR_A, MODE_BLUR_B:
                    begin
                        // edge neighbors weigh 2, corners 1, centre 4
                        acc = 4 * c + 2 * (ranked[1] + ranked[3] + ranked[4] + ranked[6])
                            + ranked[0] + ranked[2] + ranked[5] + ranked[7];
                        res = PIX_W'((acc + 8) >> 4);
                    end
                    MODE_MEAN8:
                    begin
                        acc = 0;
                        for (i = 0; i < 8; i++)
                            acc += ranked[i];
                        res = PIX_W'((acc + 4) >> 3);
                    end
                    MODE_MEAN9:
                    begin
                        acc = c;
                        for (i = 0; i < 8; i++)
                            acc += ranked[i];
                        res = PIX_W'((acc + 4) / 9);
                    end
                    default:
                        res = c;
                endcase
            end
            return PORT_W'(res);
        end
    endfunction

    function automatic window_t random_window();
        window_t           w;
        logic [PORT_W-1:0] base;
        logic [PORT_W-1:0] pick [3];
        logic [PORT_W-1:0] pix;
        int                style;
        int                i;
        begin
            style   = $urandom_range(0, 3);
            base    = PORT_W'($urandom_range(0, 65535 - 64));
            pick[0] = PORT_W'($urandom);
            pick[1] = PORT_W'($urandom);
            pick[2] = PORT_W'($urandom);
            for (i = 0; i < 9; i++)
            begin
                case (style)
                    0: pix = PORT_W'($urandom);
                    // close values: clamps land inside the window
                    1: pix = base + PORT_W'($urandom_range(0, 63));
                    2: pix = ($urandom_range(0, 2) == 0) ? '0 :
                             ($urandom_range(0, 1) == 0) ? '1 : PORT_W'($urandom);
                    // few distinct values: ties among ranks
                    default: pix = pick[$urandom_range(0, 2)];
                endcase
                if (i == 0)
                    w.centre = pix;
                else
                    w.nbr[i - 1] = pix;
            end
            w.border = ($urandom_range(0, 6) == 0);
            return w;
        end
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        begin
            if ($urandom_range(0, 3) == 0)
                return MODE_W'($urandom_range(0, 31));
            return MODE_WALK[$urandom_range(0, 7)];
        end
    endfunction

    function automatic bit count_mismatch();
        begin
            mismatches++;
            return mismatches <= MAX_REPORTS;
        end
    endfunction

    task automatic wait_drained();
        begin
            start <= 1'b0;
            while (expected_pixels.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        begin
            wait_drained();
            cfg_valid <= 1'b1;
            cfg_data  <= mode;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid   <= 1'b0;
            mode_shadow  = mode;
        end
    endtask

    task automatic send_window(input window_t w, input logic known,
                               input logic [PORT_W-1:0] known_pixel);
        begin
            start        <= 1'b1;
            centre_pixel <= w.centre;
            upper_left   <= w.nbr[0];
            upper_mid    <= w.nbr[1];
            upper_right  <= w.nbr[2];
            mid_left     <= w.nbr[3];
            mid_right    <= w.nbr[4];
            lower_left   <= w.nbr[5];
            lower_mid    <= w.nbr[6];
            lower_right  <= w.nbr[7];
            on_border    <= w.border;
            do
                @(posedge clk);
            while (busy);
            expected_pixels.push_back(known ? known_pixel : predict_filtered(mode_shadow, w));
        end
    endtask

    always @(posedge clk)
    begin : check_results
        logic [PORT_W-1:0] want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                if (count_mismatch())
                    $display("filtered_pixel %h with no item pending", filtered_pixel);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (filtered_pixel !== want && count_mismatch())
                    $display("filtered_pixel mismatch: expected %h, got %h",
                             want, filtered_pixel);
            end
        end
    end

    // End the run when no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                row;
        int                sent;
        int                phase;
        logic [MODE_W-1:0] mode;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (DIRECTED[row].mode != mode_shadow)
                write_mode(DIRECTED[row].mode);
            send_window(DIRECTED[row].win, DIRECTED[row].known, DIRECTED[row].known_pixel);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = (phase < 10) ? MODE_WALK[(phase + 7) % 10] : pick_mode();
            write_mode(mode);
            repeat ($urandom_range(30, 80))
            begin
                send_window(random_window(), 1'b0, '0);
                sent++;
                // hold off the next item now and then, but not near the end
                if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nrcb_pkg.sv
rtl/nrcb_rank.sv
rtl/nrcb_sum.sv
rtl/nrcb_final.sv
rtl/neighborhood_rank_clip_blur_3x3.sv
test/tb_neighborhood_rank_clip_blur_3x3.sv
